@@ rtl/core/motor_reply_frame_receiver_macros.svh @@
// Assertion macros used by the checker file of the reply frame receiver.
// No dependencies; the user must have clk_i and rst_ni in scope.
`ifndef MOTOR_REPLY_FRAME_RECEIVER_MACROS_SVH
`define MOTOR_REPLY_FRAME_RECEIVER_MACROS_SVH

// Property checked on every clock edge outside reset.
`define MRFR_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error("mrfr assertion failed");

// Property checked in the cycle after its trigger.
`define MRFR_ASSERT_NEXT(label, trig, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (prop)) \
    else $error("mrfr assertion failed");

`endif

@@ rtl/core/mrfr_pkg.sv @@
// Shared types and constants of the motor reply frame receiver.
// No dependencies.
package mrfr_pkg;

  localparam int unsigned FRAME_MAX   = 16;
  localparam int unsigned IDX_W       = $clog2(FRAME_MAX);
  localparam int unsigned CNT_W       = $clog2(FRAME_MAX + 1);
  localparam int unsigned MEM_DEPTH   = 2 * (2 ** IDX_W);
  localparam int unsigned MEM_AW      = IDX_W + 1;

  localparam int unsigned OP_Q_DEPTH  = 2;
  localparam int unsigned OP_Q_PW     = $clog2(OP_Q_DEPTH);
  localparam int unsigned OP_Q_CW     = $clog2(OP_Q_DEPTH + 1);
  localparam int unsigned RES_Q_DEPTH = 4;
  localparam int unsigned RES_Q_PW    = $clog2(RES_Q_DEPTH);
  localparam int unsigned RES_Q_CW    = $clog2(RES_Q_DEPTH + 1);

  localparam logic [7:0] MOTOR_ADDRESS_RST = 8'd1;
  localparam logic [7:0] TAIL_BYTE_RST     = 8'd107;

  localparam logic [7:0] CODE_VERSION  = 8'h1F;
  localparam logic [7:0] CODE_ACK_A    = 8'hF3;
  localparam logic [7:0] CODE_ACK_B    = 8'hF6;
  localparam logic [7:0] CODE_ACK_C    = 8'hFD;
  localparam logic [7:0] CODE_ACK_D    = 8'hFE;
  localparam logic [CNT_W-1:0] LEN_VERSION  = CNT_W'(5);
  localparam logic [CNT_W-1:0] LEN_ACK      = CNT_W'(4);
  localparam logic [CNT_W-1:0] LEN_CODE_MIN = CNT_W'(3);

  typedef enum logic {
    CFG_MOTOR_ADDRESS = 1'b0,
    CFG_TAIL_BYTE     = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    CMD_RX_BYTE = 2'd0,
    CMD_CONSUME = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  // Classified item between front and back
  typedef struct packed {
    cmd_e       kind;
    logic [7:0] data;
    logic [3:0] idx;
    logic       is_addr;
    logic       is_tail;
  } op_t;

  typedef struct packed {
    logic        frame_ready;
    logic [4:0]  frame_length;
    logic        is_version_reply;
    logic        is_command_reply;
    logic [7:0]  reply_code;
    logic [7:0]  reply_status;
    logic [7:0]  fw_rev;
    logic [7:0]  hw_rev;
    logic [31:0] valid_frames;
    logic [31:0] dropped_frames;
    logic [7:0]  read_data;
  } res_t;

endpackage

@@ rtl/core/motor_reply_frame_receiver.sv @@
// Top level of the motor reply frame receiver.
// Depends on mrfr_pkg, mrfr_front, mrfr_op_queue, mrfr_back, mrfr_res_queue.
//
//   channel   handshake        payload
//   input     push / full      command_i, rx_byte_i, read_index_i
//   result    empty / pop      frame_ready_o .. read_data_o (one per item)
//   config    cfg_we_i         cfg_index_i, cfg_data_i (no wait, no read-back)
//
// One item per cycle sustained while results are popped; an item's result reaches
// the result queue through the op queue, then the registered frame-store read.
// Frame bytes live in a two-bank store; a latch swaps banks instead of copying.
// Reset is asynchronous, active low, with no clearing pass; stores are only
// read below a valid length.
// A stalled result side backs up the result queue, then the op queue, then full.
module motor_reply_frame_receiver (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [7:0]  cfg_data_i,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  command_i,
  input  logic [7:0]  rx_byte_i,
  input  logic [3:0]  read_index_i,
  output logic        empty,
  input  logic        pop,
  output logic        frame_ready_o,
  output logic [4:0]  frame_length_o,
  output logic        is_version_reply_o,
  output logic        is_command_reply_o,
  output logic [7:0]  reply_code_o,
  output logic [7:0]  reply_status_o,
  output logic [7:0]  fw_rev_o,
  output logic [7:0]  hw_rev_o,
  output logic [31:0] valid_frames_o,
  output logic [31:0] dropped_frames_o,
  output logic [7:0]  read_data_o
);

  mrfr_pkg::op_t                 front_op, back_op;
  mrfr_pkg::res_t                back_res, head_res;
  logic                          q_push, q_full, q_empty, q_pop, res_push;
  logic [mrfr_pkg::RES_Q_CW-1:0] res_count;

  mrfr_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .push_i       (push),
    .q_full_i     (q_full),
    .command_i    (command_i),
    .rx_byte_i    (rx_byte_i),
    .read_index_i (read_index_i),
    .q_push_o     (q_push),
    .op_o         (front_op)
  );

  mrfr_op_queue u_op_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (q_push),
    .op_i    (front_op),
    .full_o  (q_full),
    .pop_i   (q_pop),
    .op_o    (back_op),
    .empty_o (q_empty)
  );

  mrfr_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .op_i        (back_op),
    .op_empty_i  (q_empty),
    .op_pop_o    (q_pop),
    .res_count_i (res_count),
    .res_push_o  (res_push),
    .res_o       (back_res)
  );

  mrfr_res_queue u_res_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (res_push),
    .res_i   (back_res),
    .pop_i   (pop),
    .res_o   (head_res),
    .empty_o (empty),
    .count_o (res_count)
  );

  assign full               = q_full;
  assign frame_ready_o      = head_res.frame_ready;
  assign frame_length_o     = head_res.frame_length;
  assign is_version_reply_o = head_res.is_version_reply;
  assign is_command_reply_o = head_res.is_command_reply;
  assign reply_code_o       = head_res.reply_code;
  assign reply_status_o     = head_res.reply_status;
  assign fw_rev_o           = head_res.fw_rev;
  assign hw_rev_o           = head_res.hw_rev;
  assign valid_frames_o     = head_res.valid_frames;
  assign dropped_frames_o   = head_res.dropped_frames;
  assign read_data_o        = head_res.read_data;

endmodule

@@ rtl/core/mrfr_front.sv @@
// Front end: configuration registers and classification of incoming items.
// Depends on mrfr_pkg.
module mrfr_front (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           cfg_we_i,
  input  logic           cfg_index_i,
  input  logic [7:0]     cfg_data_i,
  input  logic           push_i,
  input  logic           q_full_i,
  input  logic [1:0]     command_i,
  input  logic [7:0]     rx_byte_i,
  input  logic [3:0]     read_index_i,
  output logic           q_push_o,
  output mrfr_pkg::op_t  op_o
);

  logic [7:0] motor_address_q, motor_address_d;
  logic [7:0] tail_byte_q, tail_byte_d;

  always_comb begin
    motor_address_d = motor_address_q;
    tail_byte_d     = tail_byte_q;
    if (cfg_we_i) begin
      case (mrfr_pkg::cfg_idx_e'(cfg_index_i))
        mrfr_pkg::CFG_MOTOR_ADDRESS: motor_address_d = cfg_data_i;
        mrfr_pkg::CFG_TAIL_BYTE:     tail_byte_d     = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      motor_address_q <= mrfr_pkg::MOTOR_ADDRESS_RST;
      tail_byte_q     <= mrfr_pkg::TAIL_BYTE_RST;
    end else begin
      motor_address_q <= motor_address_d;
      tail_byte_q     <= tail_byte_d;
    end
  end

  always_comb begin
    op_o.kind    = mrfr_pkg::cmd_e'(command_i);
    op_o.data    = rx_byte_i;
    op_o.idx     = read_index_i;
    op_o.is_addr = (rx_byte_i == motor_address_q);
    op_o.is_tail = (rx_byte_i == tail_byte_q);
  end

  assign q_push_o = push_i & ~q_full_i;

endmodule

@@ rtl/core/mrfr_op_queue.sv @@
// Short queue of classified items between front and back end.
// Depends on mrfr_pkg.
module mrfr_op_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  mrfr_pkg::op_t  op_i,
  output logic           full_o,
  input  logic           pop_i,
  output mrfr_pkg::op_t  op_o,
  output logic           empty_o
);

  mrfr_pkg::op_t entry_q [mrfr_pkg::OP_Q_DEPTH];
  logic [mrfr_pkg::OP_Q_PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [mrfr_pkg::OP_Q_CW-1:0] count_q, count_d;

  assign full_o  = (count_q == mrfr_pkg::OP_Q_CW'(mrfr_pkg::OP_Q_DEPTH));
  assign empty_o = (count_q == '0);
  assign op_o    = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == mrfr_pkg::OP_Q_PW'(mrfr_pkg::OP_Q_DEPTH - 1)) ? '0
                                                                           : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == mrfr_pkg::OP_Q_PW'(mrfr_pkg::OP_Q_DEPTH - 1)) ? '0
                                                                           : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) count_d = count_q + 1'b1;
    else if (!push_i && pop_i) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= op_i;
  end

endmodule

@@ rtl/core/mrfr_back.sv @@
// Back end: frame assembly, latch, decode, counters and frame store.
// Depends on mrfr_pkg.
module mrfr_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  mrfr_pkg::op_t                   op_i,
  input  logic                            op_empty_i,
  output logic                            op_pop_o,
  input  logic [mrfr_pkg::RES_Q_CW-1:0]   res_count_i,
  output logic                            res_push_o,
  output mrfr_pkg::res_t                  res_o
);

  localparam int unsigned CNT_W = mrfr_pkg::CNT_W;
  localparam int unsigned IDX_W = mrfr_pkg::IDX_W;

  // Two banks: one assembles, the other holds the latched frame.
  // A latch swaps the roles, so no copy is needed.
  logic [7:0] mem_q [mrfr_pkg::MEM_DEPTH];
  logic [7:0] rdata_q;

  logic [CNT_W-1:0] asm_cnt_q, asm_cnt_d;
  logic             asm_bank_q, asm_bank_d;
  logic             lat_bank_q, lat_bank_d;
  logic [CNT_W-1:0] lat_len_q, lat_len_d;
  logic             pending_q, pending_d;
  logic [7:0]       code_q, code_d, status_q, status_d;
  logic [7:0]       fw_q, fw_d, hw_q, hw_d;
  logic             ver_q, ver_d, ack_q, ack_d;
  logic [31:0]      good_q, good_d, drop_q, drop_d;
  logic [7:0]       b1_q, b2_q, b3_q;
  logic             b_valid_q, b_rd_ok_q, rd_ok_d;

  logic                        fire;
  logic                        wr_en, rd_en;
  logic [mrfr_pkg::MEM_AW-1:0] wr_addr, rd_addr;
  logic [CNT_W-1:0]            new_len;

  // Credit covers the item already in the read stage.
  assign fire = !op_empty_i &&
                ((res_count_i + mrfr_pkg::RES_Q_CW'(b_valid_q)) <
                 mrfr_pkg::RES_Q_CW'(mrfr_pkg::RES_Q_DEPTH));
  assign op_pop_o = fire;

  assign new_len = asm_cnt_q + 1'b1;
  assign wr_addr = {asm_bank_q, asm_cnt_q[IDX_W-1:0]};
  assign rd_addr = {lat_bank_q, IDX_W'(op_i.idx)};

  always_comb begin
    asm_cnt_d  = asm_cnt_q;
    asm_bank_d = asm_bank_q;
    lat_bank_d = lat_bank_q;
    lat_len_d  = lat_len_q;
    pending_d  = pending_q;
    code_d     = code_q;
    status_d   = status_q;
    fw_d       = fw_q;
    hw_d       = hw_q;
    ver_d      = ver_q;
    ack_d      = ack_q;
    good_d     = good_q;
    drop_d     = drop_q;
    wr_en      = 1'b0;
    rd_en      = 1'b0;
    rd_ok_d    = 1'b0;
    if (fire) begin
      case (op_i.kind)
        mrfr_pkg::CMD_RX_BYTE: begin
          if (asm_cnt_q == '0) begin
            if (op_i.is_addr) begin
              wr_en     = 1'b1;
              asm_cnt_d = CNT_W'(1);
            end
          end else if (asm_cnt_q >= CNT_W'(mrfr_pkg::FRAME_MAX)) begin
            drop_d    = drop_q + 32'd1;
            asm_cnt_d = '0;
          end else begin
            wr_en     = 1'b1;
            asm_cnt_d = new_len;
            if (op_i.is_tail) begin
              asm_cnt_d = '0;
              if (!pending_q) begin
                lat_bank_d = asm_bank_q;
                asm_bank_d = ~asm_bank_q;
                lat_len_d  = new_len;
                pending_d  = 1'b1;
                good_d     = good_q + 32'd1;
                // Decode bytes 1..3 were captured on earlier transfers
                code_d     = 8'd0;
                status_d   = 8'd0;
                fw_d       = 8'd0;
                hw_d       = 8'd0;
                ver_d      = 1'b0;
                ack_d      = 1'b0;
                if (new_len >= mrfr_pkg::LEN_CODE_MIN) begin
                  code_d = b1_q;
                  if (new_len == mrfr_pkg::LEN_VERSION && b1_q == mrfr_pkg::CODE_VERSION) begin
                    fw_d  = b2_q;
                    hw_d  = b3_q;
                    ver_d = 1'b1;
                  end else if (new_len == mrfr_pkg::LEN_ACK &&
                               (b1_q inside {mrfr_pkg::CODE_ACK_A, mrfr_pkg::CODE_ACK_B,
                                             mrfr_pkg::CODE_ACK_C, mrfr_pkg::CODE_ACK_D})) begin
                    status_d = b2_q;
                    ack_d    = 1'b1;
                  end
                end
              end else begin
                drop_d = drop_q + 32'd1;
              end
            end
          end
        end
        mrfr_pkg::CMD_CONSUME: begin
          pending_d = 1'b0;
          lat_len_d = '0;
          ver_d     = 1'b0;
          ack_d     = 1'b0;
        end
        mrfr_pkg::CMD_READ: begin
          rd_ok_d = ({1'b0, op_i.idx} < 5'(lat_len_q)) &&
                    (32'(op_i.idx) < mrfr_pkg::FRAME_MAX);
          rd_en   = rd_ok_d;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      asm_cnt_q  <= '0;
      asm_bank_q <= 1'b0;
      lat_bank_q <= 1'b1;
      lat_len_q  <= '0;
      pending_q  <= 1'b0;
      code_q     <= '0;
      status_q   <= '0;
      fw_q       <= '0;
      hw_q       <= '0;
      ver_q      <= 1'b0;
      ack_q      <= 1'b0;
      good_q     <= '0;
      drop_q     <= '0;
      b_valid_q  <= 1'b0;
      b_rd_ok_q  <= 1'b0;
    end else begin
      asm_cnt_q  <= asm_cnt_d;
      asm_bank_q <= asm_bank_d;
      lat_bank_q <= lat_bank_d;
      lat_len_q  <= lat_len_d;
      pending_q  <= pending_d;
      code_q     <= code_d;
      status_q   <= status_d;
      fw_q       <= fw_d;
      hw_q       <= hw_d;
      ver_q      <= ver_d;
      ack_q      <= ack_d;
      good_q     <= good_d;
      drop_q     <= drop_d;
      b_valid_q  <= fire;
      b_rd_ok_q  <= rd_ok_d;
    end
  end

  // Shadow copies of the bytes that decoding needs
  always_ff @(posedge clk_i) begin
    if (wr_en && asm_cnt_q == CNT_W'(1)) b1_q <= op_i.data;
    if (wr_en && asm_cnt_q == CNT_W'(2)) b2_q <= op_i.data;
    if (wr_en && asm_cnt_q == CNT_W'(3)) b3_q <= op_i.data;
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= op_i.data;
    if (rd_en) rdata_q <= mem_q[rd_addr];
  end

  // Read stage: state registers already show the post-update values
  assign res_push_o = b_valid_q;
  always_comb begin
    res_o.frame_ready      = pending_q;
    res_o.frame_length     = 5'(lat_len_q);
    res_o.is_version_reply = ver_q;
    res_o.is_command_reply = ack_q;
    res_o.reply_code       = code_q;
    res_o.reply_status     = status_q;
    res_o.fw_rev           = fw_q;
    res_o.hw_rev           = hw_q;
    res_o.valid_frames     = good_q;
    res_o.dropped_frames   = drop_q;
    res_o.read_data        = b_rd_ok_q ? rdata_q : 8'd0;
  end

endmodule

@@ rtl/core/mrfr_res_queue.sv @@
// Result queue feeding the output ports.
// Depends on mrfr_pkg.
module mrfr_res_queue (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           push_i,
  input  mrfr_pkg::res_t                 res_i,
  input  logic                           pop_i,
  output mrfr_pkg::res_t                 res_o,
  output logic                           empty_o,
  output logic [mrfr_pkg::RES_Q_CW-1:0]  count_o
);

  mrfr_pkg::res_t entry_q [mrfr_pkg::RES_Q_DEPTH];
  logic [mrfr_pkg::RES_Q_PW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [mrfr_pkg::RES_Q_CW-1:0] count_q, count_d;
  logic                          do_pop;

  assign empty_o = (count_q == '0);
  assign count_o = count_q;
  assign res_o   = entry_q[rd_ptr_q];
  assign do_pop  = pop_i & ~empty_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == mrfr_pkg::RES_Q_PW'(mrfr_pkg::RES_Q_DEPTH - 1)) ? '0
                                                                             : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == mrfr_pkg::RES_Q_PW'(mrfr_pkg::RES_Q_DEPTH - 1)) ? '0
                                                                             : rd_ptr_q + 1'b1;
    end
    if (push_i && !do_pop) count_d = count_q + 1'b1;
    else if (!push_i && do_pop) count_d = count_q - 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) entry_q[wr_ptr_q] <= res_i;
  end

endmodule

@@ rtl/core/mrfr_checker.sv @@
// Port-level checks of the motor reply frame receiver, bound to the top level.
// Depends on motor_reply_frame_receiver_macros.svh and mrfr_pkg.
`include "motor_reply_frame_receiver_macros.svh"

module mrfr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        cfg_we_i,
  input logic        cfg_index_i,
  input logic [7:0]  cfg_data_i,
  input logic        push,
  input logic        full,
  input logic [1:0]  command_i,
  input logic [7:0]  rx_byte_i,
  input logic [3:0]  read_index_i,
  input logic        empty,
  input logic        pop,
  input logic        frame_ready_o,
  input logic [4:0]  frame_length_o,
  input logic        is_version_reply_o,
  input logic        is_command_reply_o,
  input logic [7:0]  reply_code_o,
  input logic [7:0]  reply_status_o,
  input logic [7:0]  fw_rev_o,
  input logic [7:0]  hw_rev_o,
  input logic [31:0] valid_frames_o,
  input logic [31:0] dropped_frames_o,
  input logic [7:0]  read_data_o
);

  logic ver_ok, ack_ok;

  assign ver_ok = frame_ready_o && (frame_length_o == mrfr_pkg::LEN_VERSION) &&
                  (reply_code_o == mrfr_pkg::CODE_VERSION);
  assign ack_ok = frame_ready_o && (frame_length_o == mrfr_pkg::LEN_ACK) &&
                  !is_version_reply_o;

  // A latched frame always has a length; after consume both are clear.
  `MRFR_ASSERT(a_ready_len, empty || (frame_ready_o == (frame_length_o != 5'd0)))

  // Version flag only with a five-byte frame carrying the version code.
  `MRFR_ASSERT(a_version, empty || !is_version_reply_o || ver_ok)

  // Acknowledge flag only with a four-byte frame.
  `MRFR_ASSERT(a_ack, empty || !is_command_reply_o || ack_ok)

  // Read data comes only from a latched frame.
  `MRFR_ASSERT(a_read_src, empty || read_data_o == 8'd0 || frame_length_o != 5'd0)

  // A result not taken stays put.
  `MRFR_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(valid_frames_o) && $stable(read_data_o))

endmodule

bind motor_reply_frame_receiver mrfr_checker u_mrfr_checker (.*);
